@@ hdl/mono_page_framebuffer_rasterizer_macros.svh @@
// Assertion helpers for the rasterizer top module.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef MONO_PAGE_FRAMEBUFFER_RASTERIZER_MACROS_SVH
`define MONO_PAGE_FRAMEBUFFER_RASTERIZER_MACROS_SVH

// Same-cycle implication.
`define MPFR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MPFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/mpfr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfr_pkg
// Shared types and constants of the page framebuffer rasterizer.
// ----------------------------------------------------------------------------
package mpfr_pkg;

  // Framebuffer geometry.
  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = 10;
  localparam int PAGE_BITS   = 8;

  // Command codes.
  localparam logic [2:0] CMD_PIXEL       = 3'd0;
  localparam logic [2:0] CMD_LINE        = 3'd1;
  localparam logic [2:0] CMD_RECT_LINE   = 3'd2;
  localparam logic [2:0] CMD_RECT_FILL   = 3'd3;
  localparam logic [2:0] CMD_CIRC_LINE   = 3'd4;
  localparam logic [2:0] CMD_CIRC_FILL   = 3'd5;
  localparam logic [2:0] CMD_READ        = 3'd6;
  localparam logic [2:0] CMD_UNUSED      = 3'd7;

  // Internal coordinate: wide enough for a center plus or minus a radius.
  typedef logic signed [12:0] coord_t;

  // One pixel offered by the line engine to the plot unit.
  typedef struct packed {
    logic   valid;
    coord_t x;
    coord_t y;
    logic   on;
  } pix_req_t;

  // Memory accesses issued by the plot unit.
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
  } mem_req_t;

endpackage

@@ hdl/mpfr_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfr_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module mpfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/mpfr_plot.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfr_plot
// Clips one pixel, then sets or clears its bit by read-modify-write.
// ----------------------------------------------------------------------------
module mpfr_plot
  import mpfr_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  pix_req_t   pix,
  output logic       ready,
  output mem_req_t   mem,
  input  logic [7:0] rd_data
);

  localparam logic signed [13:0] W_S = 14'(SCREEN_WIDTH);
  localparam logic signed [13:0] H_S = 14'(SCREEN_HEIGHT);
  localparam logic [10:0]        W_U = 11'(SCREEN_WIDTH);

  logic              ph_r, ph_nxt;
  logic [ADDR_W-1:0] addr_r;
  logic [2:0]        bit_r;
  logic              on_r;
  logic              on_screen;
  logic [21:0]       addr_full;
  logic              do_rmw;
  logic [7:0]        mask;

  // Clip against the screen and form the page address.
  always_comb begin
    on_screen = (pix.x >= 13'sd0) && (14'(pix.x) < W_S) &&
                (pix.y >= 13'sd0) && (14'(pix.y) < H_S);
    addr_full = 22'(pix.y[12:3] * W_U) + 22'(pix.x[11:0]);
    do_rmw    = pix.valid && !ph_r && on_screen && (addr_full < 22'(STORE_DEPTH));
  end

  assign ready = !ph_r;

  // Read the addressed byte while ph_r is low, then write the modified byte while ph_r is high.
  always_comb begin
    ph_nxt       = ph_r;
    mask         = 8'(1) << bit_r;
    mem.rd_en    = do_rmw;
    mem.rd_addr  = addr_full[ADDR_W-1:0];
    mem.wr_en    = ph_r;
    mem.wr_addr  = addr_r;
    mem.wr_data  = on_r ? (rd_data | mask) : (rd_data & ~mask);
    if (ph_r) begin
      ph_nxt = 1'b0;
    end else if (do_rmw) begin
      ph_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_rmw) begin
      addr_r <= addr_full[ADDR_W-1:0];
      bit_r  <= pix.y[2:0];
      on_r   <= pix.on;
    end
  end

endmodule

@@ hdl/mpfr_line.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfr_line
// Bresenham line stepper: offers one pixel at a time to the plot unit.
// ----------------------------------------------------------------------------
module mpfr_line
  import mpfr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  coord_t   x0,
  input  coord_t   y0,
  input  coord_t   x1,
  input  coord_t   y1,
  input  logic     on,
  input  logic     pix_ready,
  output pix_req_t pix,
  output logic     done,
  output logic     idle
);

  logic                act_r, act_nxt;
  coord_t              x_r, y_r, xe_r, ye_r;
  logic signed [13:0]  dx_r, dy_r;
  logic                sx_neg_r, sy_neg_r, on_r;
  logic signed [16:0]  err_r;
  logic signed [13:0]  dxs, dys, dx_abs, dy_abs;
  logic signed [16:0]  e2, err_a;
  logic                step, last, x_step, y_step;

  // Setup values from the endpoints.
  always_comb begin
    dxs    = 14'(x1) - 14'(x0);
    dys    = 14'(y1) - 14'(y0);
    dx_abs = dxs[13] ? -dxs : dxs;
    dy_abs = dys[13] ? -dys : dys;
  end

  assign pix.valid = act_r;
  assign pix.x     = x_r;
  assign pix.y     = y_r;
  assign pix.on    = on_r;
  assign idle      = !act_r;
  assign step      = act_r && pix_ready;
  assign last      = (x_r == xe_r) && (y_r == ye_r);
  assign done      = step && last;
  assign e2        = err_r <<< 1;

  // Both error tests use the same doubled error term.
  always_comb begin
    x_step = (e2 >= 17'(dy_r));
    y_step = (e2 <= 17'(dx_r));
    err_a  = err_r;
    if (x_step) begin
      err_a = err_a + 17'(dy_r);
    end
    if (y_step) begin
      err_a = err_a + 17'(dx_r);
    end
  end

  always_comb begin
    act_nxt = act_r;
    if (start) begin
      act_nxt = 1'b1;
    end else if (done) begin
      act_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else begin
      act_r <= act_nxt;
    end
  end

  // Error term and position update, one pixel per accepted step.
  always_ff @(posedge clk) begin
    if (start) begin
      x_r      <= x0;
      y_r      <= y0;
      xe_r     <= x1;
      ye_r     <= y1;
      dx_r     <= dx_abs;
      dy_r     <= -dy_abs;
      sx_neg_r <= !(x0 < x1);
      sy_neg_r <= !(y0 < y1);
      on_r     <= on;
      err_r    <= 17'(dx_abs) - 17'(dy_abs);
    end else if (step && !last) begin
      if (x_step) begin
        x_r <= sx_neg_r ? x_r - 13'sd1 : x_r + 13'sd1;
      end
      if (y_step) begin
        y_r <= sy_neg_r ? y_r - 13'sd1 : y_r + 13'sd1;
      end
      err_r <= err_a;
    end
  end

endmodule

@@ hdl/mono_page_framebuffer_rasterizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_page_framebuffer_rasterizer
// Pixel, line, rectangle and circle drawing into a one-bit paged framebuffer, and byte reads.
// ----------------------------------------------------------------------------
// Usage:
// A command item is taken when start is high and busy is low. Drawing
// commands are broken into line segments; a Bresenham stepper offers pixels
// to a plot unit that clips each one and sets or clears its bit by a
// read-modify-write of the 1024 x 8 framebuffer RAM.
// Every item gives exactly one result: out_valid is high for one cycle with
// out_read_data, the addressed byte for a read and zero otherwise.
// Steps: an on-screen pixel takes a RAM read, then a write; an off-screen
// pixel takes no RAM access. Each line segment passes through the ISSUE,
// WAIT and NEXT states; each drawing item ends in FIN. A read item returns
// the byte read at acceptance through READ and the output register. The
// RAM's single read port and the read-modify-write set the pixel rate.
// After reset a clearing pass writes zero to all 1024 bytes, holding busy
// high throughout. The receiver cannot stall results; none are held.
// ----------------------------------------------------------------------------
`include "mono_page_framebuffer_rasterizer_macros.svh"

module mono_page_framebuffer_rasterizer
  import mpfr_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_command,
  input  logic signed [10:0] in_x_start,
  input  logic signed [10:0] in_y_start,
  input  logic signed [10:0] in_x_end,
  input  logic signed [10:0] in_y_end,
  input  logic [9:0]         in_rect_width,
  input  logic [9:0]         in_rect_height,
  input  logic [9:0]         in_radius,
  input  logic               in_pixel_on,
  input  logic [9:0]         in_byte_index,
  output logic               out_valid,
  output logic [7:0]         out_read_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_ISSUE = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_NEXT  = 3'd4;
  localparam logic [2:0] ST_READ  = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_r, clr_nxt;
  logic [9:0]         seg_r, seg_nxt;
  logic signed [11:0] px_r, px_nxt, py_r, py_nxt;
  logic signed [15:0] err_r, err_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_data_r, out_data_nxt;
  logic [2:0]         cmd_r;
  coord_t             xs_r, ys_r, xe_r, ye_r, right_r, bottom_r;
  logic [9:0]         h_r;
  logic               on_r;

  coord_t             lx0, ly0, lx1, ly1;
  logic               ln_start, ln_done, ln_idle, pl_ready;
  pix_req_t           pix;
  mem_req_t           pmem;
  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_wa, ram_ra;
  logic [7:0]         ram_wd, ram_rd;
  logic               last_seg;
  logic signed [11:0] py_n, px_n;
  logic signed [15:0] e1;
  coord_t             cpx, cpy;

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

  // Latch the command item.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_r    <= in_command;
      xs_r     <= 13'(in_x_start);
      ys_r     <= 13'(in_y_start);
      xe_r     <= 13'(in_x_end);
      ye_r     <= 13'(in_y_end);
      right_r  <= 13'(in_x_start) + $signed({3'b000, in_rect_width}) - 13'sd1;
      bottom_r <= 13'(in_y_start) + $signed({3'b000, in_rect_height}) - 13'sd1;
      h_r      <= in_rect_height;
      on_r     <= in_pixel_on;
    end
  end

  // Segment endpoints for the current command and step.
  always_comb begin
    cpx = 13'(px_r);
    cpy = 13'(py_r);
    lx0 = xs_r;
    ly0 = ys_r;
    lx1 = xs_r;
    ly1 = ys_r;
    case (cmd_r)
      CMD_LINE: begin
        lx1 = xe_r;
        ly1 = ye_r;
      end
      CMD_RECT_LINE: begin
        case (seg_r[1:0])
          2'd0: begin lx1 = right_r; end
          2'd1: begin ly0 = bottom_r; lx1 = right_r; ly1 = bottom_r; end
          2'd2: begin ly1 = bottom_r; end
          default: begin lx0 = right_r; lx1 = right_r; ly1 = bottom_r; end
        endcase
      end
      CMD_RECT_FILL: begin
        ly0 = ys_r + $signed({3'b000, seg_r});
        ly1 = ly0;
        lx1 = right_r;
      end
      CMD_CIRC_LINE: begin
        case (seg_r[2:0])
          3'd0: begin lx0 = xs_r + cpx; ly0 = ys_r + cpy; end
          3'd1: begin lx0 = xs_r + cpy; ly0 = ys_r + cpx; end
          3'd2: begin lx0 = xs_r - cpy; ly0 = ys_r + cpx; end
          3'd3: begin lx0 = xs_r - cpx; ly0 = ys_r + cpy; end
          3'd4: begin lx0 = xs_r - cpx; ly0 = ys_r - cpy; end
          3'd5: begin lx0 = xs_r - cpy; ly0 = ys_r - cpx; end
          3'd6: begin lx0 = xs_r + cpy; ly0 = ys_r - cpx; end
          default: begin lx0 = xs_r + cpx; ly0 = ys_r - cpy; end
        endcase
        lx1 = lx0;
        ly1 = ly0;
      end
      CMD_CIRC_FILL: begin
        case (seg_r[1:0])
          2'd0: begin lx0 = xs_r - cpx; lx1 = xs_r + cpx; ly0 = ys_r + cpy; end
          2'd1: begin lx0 = xs_r - cpx; lx1 = xs_r + cpx; ly0 = ys_r - cpy; end
          2'd2: begin lx0 = xs_r - cpy; lx1 = xs_r + cpy; ly0 = ys_r + cpx; end
          default: begin lx0 = xs_r - cpy; lx1 = xs_r + cpy; ly0 = ys_r - cpx; end
        endcase
        ly1 = ly0;
      end
      default: begin
      end
    endcase
  end

  // Midpoint circle update between groups of segments.
  always_comb begin
    py_n = py_r + 12'sd1;
    e1   = (err_r <= 16'sd0) ? err_r + 16'(py_n <<< 1) + 16'sd1 : err_r;
    px_n = (e1 > 16'sd0) ? px_r - 12'sd1 : px_r;
    last_seg = (cmd_r == CMD_CIRC_LINE) ? (seg_r[2:0] == 3'd7) : (seg_r[1:0] == 2'd3);
  end

  // Command sequencer.
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    seg_nxt       = seg_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    err_nxt       = err_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    ln_start      = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == ADDR_W'(STORE_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          seg_nxt = '0;
          px_nxt  = 12'($signed({1'b0, in_radius}));
          py_nxt  = '0;
          err_nxt = '0;
          if (in_command == CMD_READ) begin
            state_nxt = ST_READ;
          end else if (in_command == CMD_UNUSED ||
                       (in_command == CMD_RECT_FILL && in_rect_height == 10'd0)) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        ln_start  = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (ln_done) begin
          state_nxt = ST_NEXT;
        end
      end
      ST_NEXT: begin
        state_nxt = ST_ISSUE;
        seg_nxt   = seg_r + 10'd1;
        case (cmd_r)
          CMD_RECT_LINE: begin
            if (seg_r[1:0] == 2'd3) begin
              state_nxt = ST_FIN;
            end
          end
          CMD_RECT_FILL: begin
            if (seg_r + 10'd1 == h_r) begin
              state_nxt = ST_FIN;
            end
          end
          CMD_CIRC_LINE, CMD_CIRC_FILL: begin
            if (last_seg) begin
              seg_nxt = '0;
              py_nxt  = py_n;
              px_nxt  = px_n;
              err_nxt = (e1 > 16'sd0) ? e1 - 16'(px_n <<< 1) - 16'sd1 : e1;
              if (px_n < py_n) begin
                state_nxt = ST_FIN;
              end
            end
          end
          default: begin
            state_nxt = ST_FIN;
          end
        endcase
      end
      ST_READ: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = ram_rd;
        state_nxt     = ST_IDLE;
      end
      ST_FIN: begin
        if (pl_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = 8'd0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seg_r      <= seg_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
  end

  // RAM port selection: clearing pass, byte read, or plot unit.
  always_comb begin
    ram_we = (state_r == ST_CLEAR) ? 1'b1 : pmem.wr_en;
    ram_wa = (state_r == ST_CLEAR) ? clr_r : pmem.wr_addr;
    ram_wd = (state_r == ST_CLEAR) ? 8'd0 : pmem.wr_data;
    ram_re = (state_r == ST_IDLE) ? 1'b1 : pmem.rd_en;
    ram_ra = (state_r == ST_IDLE) ? in_byte_index : pmem.rd_addr;
  end

  mpfr_line u_line (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (ln_start),
    .x0        (lx0),
    .y0        (ly0),
    .x1        (lx1),
    .y1        (ly1),
    .on        (on_r || (cmd_r != CMD_PIXEL && cmd_r != CMD_LINE)),
    .pix_ready (pl_ready),
    .pix       (pix),
    .done      (ln_done),
    .idle      (ln_idle)
  );

  mpfr_plot #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_plot (
    .clk     (clk),
    .rst_n   (rst_n),
    .pix     (pix),
    .ready   (pl_ready),
    .mem     (pmem),
    .rd_data (ram_rd)
  );

  mpfr_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_en   (ram_re),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  // Checks.
  `MPFR_ASSERT_NEXT(a_out_one_cycle, out_valid, !out_valid, "result strobe held twice")
  `MPFR_ASSERT_IMPL(a_start_idle, ln_start, ln_idle, "line started while stepping")
  `MPFR_ASSERT_IMPL(a_no_plot_in_clear, state_r == ST_CLEAR, !pmem.wr_en,
                    "plot write during clear")
  `MPFR_ASSERT_IMPL(a_done_fin, out_valid && out_read_data != 8'd0, $past(state_r) == ST_READ,
                    "nonzero result from a drawing item")

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the paged framebuffer rasterizer.
// ----------------------------------------------------------------------------
// A queue of command items is filled at time zero and fed to the block by a
// clocked driver that idles a random number of cycles between items. The
// bench keeps its own copy of the framebuffer. When an item is accepted, the
// bench draws the command into that copy and queues the byte the block should
// return. A clocked monitor compares each returned byte with the oldest
// queued byte.
// ----------------------------------------------------------------------------
module testbench;
  import mpfr_pkg::*;

  localparam int SCR_W     = 128;
  localparam int SCR_H     = 64;
  localparam int MAX_CYC   = 20000000;

  typedef struct {
    logic [2:0]         command;
    logic signed [10:0] x_start;
    logic signed [10:0] y_start;
    logic signed [10:0] x_end;
    logic signed [10:0] y_end;
    logic [9:0]         rect_width;
    logic [9:0]         rect_height;
    logic [9:0]         radius;
    logic               pixel_on;
    logic [9:0]         byte_index;
  } draw_cmd_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         in_command = '0;
  logic signed [10:0] in_x_start = '0;
  logic signed [10:0] in_y_start = '0;
  logic signed [10:0] in_x_end = '0;
  logic signed [10:0] in_y_end = '0;
  logic [9:0]         in_rect_width = '0;
  logic [9:0]         in_rect_height = '0;
  logic [9:0]         in_radius = '0;
  logic               in_pixel_on = 1'b0;
  logic [9:0]         in_byte_index = '0;
  logic               out_valid;
  logic [7:0]         out_read_data;

  draw_cmd_t  cmd_queue[$];
  draw_cmd_t  cur_cmd;
  logic [7:0] expected_bytes[$];
  logic [7:0] shadow_fb[STORE_DEPTH];
  int         idle_cycles = 0;
  int         cycle_count = 0;
  int         total_items = 0;
  int         results_seen = 0;
  bit         failed = 1'b0;

  mono_page_framebuffer_rasterizer #(
    .SCREEN_WIDTH (SCR_W),
    .SCREEN_HEIGHT(SCR_H)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_command    (in_command),
    .in_x_start    (in_x_start),
    .in_y_start    (in_y_start),
    .in_x_end      (in_x_end),
    .in_y_end      (in_y_end),
    .in_rect_width (in_rect_width),
    .in_rect_height(in_rect_height),
    .in_radius     (in_radius),
    .in_pixel_on   (in_pixel_on),
    .in_byte_index (in_byte_index),
    .out_valid     (out_valid),
    .out_read_data (out_read_data)
  );

  always #5 clk = ~clk;

  // Set or clear one pixel of the shadow framebuffer, clipped to the screen.
  function automatic void fb_plot(int x, int y, bit on);
    int addr;
    if (x < 0 || x >= SCR_W || y < 0 || y >= SCR_H) return;
    addr = (y / PAGE_BITS) * SCR_W + x;
    if (addr >= STORE_DEPTH) return;
    shadow_fb[addr][y % PAGE_BITS] = on;
  endfunction

  // Bresenham line between two end points, both inclusive.
  function automatic void fb_line(int x0, int y0, int x1, int y1, bit on);
    int dx, dy, sx, sy, err, e2;
    dx  = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy  = -((y1 > y0) ? y1 - y0 : y0 - y1);
    sx  = (x0 < x1) ? 1 : -1;
    sy  = (y0 < y1) ? 1 : -1;
    err = dx + dy;
    forever begin
      fb_plot(x0, y0, on);
      if (x0 == x1 && y0 == y1) break;
      e2 = 2 * err;
      if (e2 >= dy) begin
        err += dy;
        x0  += sx;
      end
      if (e2 <= dx) begin
        err += dx;
        y0  += sy;
      end
    end
  endfunction

  // Midpoint circle, outline or filled with horizontal spans.
  function automatic void fb_circle(int xc, int yc, int r, bit fill);
    int px, py, err;
    px  = r;
    py  = 0;
    err = 0;
    while (px >= py) begin
      if (fill) begin
        fb_line(xc - px, yc + py, xc + px, yc + py, 1'b1);
        fb_line(xc - px, yc - py, xc + px, yc - py, 1'b1);
        fb_line(xc - py, yc + px, xc + py, yc + px, 1'b1);
        fb_line(xc - py, yc - px, xc + py, yc - px, 1'b1);
      end else begin
        fb_plot(xc + px, yc + py, 1'b1);
        fb_plot(xc + py, yc + px, 1'b1);
        fb_plot(xc - py, yc + px, 1'b1);
        fb_plot(xc - px, yc + py, 1'b1);
        fb_plot(xc - px, yc - py, 1'b1);
        fb_plot(xc - py, yc - px, 1'b1);
        fb_plot(xc + py, yc - px, 1'b1);
        fb_plot(xc + px, yc - py, 1'b1);
      end
      py += 1;
      if (err <= 0) err += 2 * py + 1;
      if (err > 0) begin
        px  -= 1;
        err -= 2 * px + 1;
      end
    end
  endfunction

  // Apply one command to the shadow framebuffer and return the byte it reads.
  function automatic logic [7:0] draw_and_read(draw_cmd_t c);
    int x, y, w, h, right, bottom;
    x      = int'(c.x_start);
    y      = int'(c.y_start);
    w      = int'(c.rect_width);
    h      = int'(c.rect_height);
    right  = x + w - 1;
    bottom = y + h - 1;
    case (c.command)
      CMD_PIXEL: fb_plot(x, y, c.pixel_on);
      CMD_LINE:  fb_line(x, y, int'(c.x_end), int'(c.y_end), c.pixel_on);
      CMD_RECT_LINE: begin
        fb_line(x, y, right, y, 1'b1);
        fb_line(x, bottom, right, bottom, 1'b1);
        fb_line(x, y, x, bottom, 1'b1);
        fb_line(right, y, right, bottom, 1'b1);
      end
      CMD_RECT_FILL: begin
        for (int row = y; row < y + h; row++) fb_line(x, row, right, row, 1'b1);
      end
      CMD_CIRC_LINE: fb_circle(x, y, int'(c.radius), 1'b0);
      CMD_CIRC_FILL: fb_circle(x, y, int'(c.radius), 1'b1);
      CMD_READ:  return shadow_fb[c.byte_index];
      default: ;
    endcase
    return 8'h00;
  endfunction

  function automatic draw_cmd_t make_cmd(logic [2:0] op, int xs, int ys, int xe, int ye,
                                         int w, int h, int r, bit on, int idx);
    draw_cmd_t c;
    c.command     = op;
    c.x_start     = 11'(xs);
    c.y_start     = 11'(ys);
    c.x_end       = 11'(xe);
    c.y_end       = 11'(ye);
    c.rect_width  = 10'(w);
    c.rect_height = 10'(h);
    c.radius      = 10'(r);
    c.pixel_on    = on;
    c.byte_index  = 10'(idx);
    return c;
  endfunction

  // Coordinate mostly near the screen, sometimes anywhere in the field.
  function automatic int rand_coord();
    if ($urandom_range(0, 9) == 0) return int'($signed(11'($urandom_range(0, 2047))));
    return int'($urandom_range(0, 210)) - 40;
  endfunction

  function automatic int rand_size(int full_max);
    if ($urandom_range(0, 29) == 0) return $urandom_range(0, full_max);
    return $urandom_range(0, 40);
  endfunction

  // Directed items, then random items.
  initial begin
    draw_cmd_t c;
    logic [2:0] op;
    for (int i = 0; i < STORE_DEPTH; i++) shadow_fb[i] = 8'h00;

    cmd_queue.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_PIXEL, 0, 0, 0, 0, 0, 0, 0, 1, 0));
    cmd_queue.push_back(make_cmd(CMD_PIXEL, 127, 63, 0, 0, 0, 0, 0, 1, 0));
    cmd_queue.push_back(make_cmd(CMD_PIXEL, -1, 5, 0, 0, 0, 0, 0, 1, 0));
    cmd_queue.push_back(make_cmd(CMD_PIXEL, 128, 64, 0, 0, 0, 0, 0, 1, 0));
    cmd_queue.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1023));
    cmd_queue.push_back(make_cmd(CMD_LINE, -1024, -1024, 1023, 1023, 0, 0, 0, 1, 0));
    cmd_queue.push_back(make_cmd(CMD_LINE, 1023, -1024, -1024, 1023, 0, 0, 0, 1, 0));
    cmd_queue.push_back(make_cmd(CMD_LINE, 10, 10, 100, 10, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 138));
    cmd_queue.push_back(make_cmd(CMD_RECT_LINE, 5, 5, 0, 0, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_RECT_LINE, -500, -500, 0, 0, 1023, 1023, 0, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_RECT_FILL, 20, 20, 0, 0, 10, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_RECT_FILL, 30, -500, 0, 0, 0, 1023, 0, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_RECT_FILL, -400, 40, 0, 0, 1023, 2, 0, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_CIRC_LINE, 64, 32, 0, 0, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_CIRC_LINE, 64, 32, 0, 0, 0, 0, 1023, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_CIRC_FILL, 90, 30, 0, 0, 0, 0, 20, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_CIRC_FILL, 10, 10, 0, 0, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_UNUSED, 1, 1, 1, 1, 1, 1, 1, 1, 1));
    cmd_queue.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 500));
    cmd_queue.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 650));

    for (int n = 0; n < 730; n++) begin
      case ($urandom_range(0, 19))
        0, 1, 2:     op = CMD_PIXEL;
        3, 4, 5:     op = CMD_LINE;
        6, 7:        op = CMD_RECT_LINE;
        8:           op = CMD_RECT_FILL;
        9, 10:       op = CMD_CIRC_LINE;
        11:          op = CMD_CIRC_FILL;
        19:          op = ($urandom_range(0, 3) == 0) ? CMD_UNUSED : CMD_READ;
        default:     op = CMD_READ;
      endcase
      c = make_cmd(op, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                   rand_size(1023), rand_size(1023), rand_size(1023),
                   $urandom_range(0, 3) != 0, $urandom_range(0, 1023));
      // Keep filled shapes bounded so the run stays short.
      if (op == CMD_RECT_FILL && c.rect_width > 64 && c.rect_height > 64)
        c.rect_height = 10'($urandom_range(0, 64));
      if (op == CMD_CIRC_FILL && c.radius > 60) c.radius = 10'($urandom_range(0, 60));
      cmd_queue.push_back(c);
    end
    total_items = cmd_queue.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Every item returns exactly one result.
    wait (results_seen >= total_items);
    repeat (50) @(posedge clk);
    if (!failed && results_seen == total_items && expected_bytes.size() == 0) begin
      $display("** mono_page_framebuffer_rasterizer: PASSED **");
    end else begin
      $display("** mono_page_framebuffer_rasterizer: FAILED **");
    end
    $finish;
  end

  // Driver: predict on acceptance, then present the next item after an optional gap.
  always @(posedge clk) begin
    logic accepted;
    accepted = start && !busy;
    if (rst_n) begin
      if (accepted) expected_bytes.push_back(draw_and_read(cur_cmd));
      if (!start || accepted) begin
        if (idle_cycles > 0) begin
          idle_cycles--;
          start <= 1'b0;
        end else if (cmd_queue.size() > 0) begin
          cur_cmd = cmd_queue.pop_front();
          in_command     <= cur_cmd.command;
          in_x_start     <= cur_cmd.x_start;
          in_y_start     <= cur_cmd.y_start;
          in_x_end       <= cur_cmd.x_end;
          in_y_end       <= cur_cmd.y_end;
          in_rect_width  <= cur_cmd.rect_width;
          in_rect_height <= cur_cmd.rect_height;
          in_radius      <= cur_cmd.radius;
          in_pixel_on    <= cur_cmd.pixel_on;
          in_byte_index  <= cur_cmd.byte_index;
          start          <= 1'b1;
          // At least half the items follow back to back.
          idle_cycles = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: each returned byte against the oldest expected byte.
  always @(posedge clk) begin
    logic [7:0] want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (expected_bytes.size() == 0) begin
        $error("unexpected result: read_data %0h", out_read_data);
        failed = 1'b1;
      end else begin
        want = expected_bytes.pop_front();
        if (out_read_data !== want) begin
          $error("read_data mismatch: expected %0h, actual %0h", want, out_read_data);
          failed = 1'b1;
        end
      end
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYC) begin
      $display("** mono_page_framebuffer_rasterizer: FAILED **");
      $finish;
    end
  end

endmodule
